// ===== hdl/nss_pkg.sv =====
`timescale 1ns / 1ps

package nss_pkg;

   localparam int COUNT_W  = 7;
   localparam int LABEL_W  = 6;
   localparam int RADIUS_W = 15;
   localparam int ATTR_W   = RADIUS_W + LABEL_W;
   localparam int BEST_W   = 16;
   localparam int IN_W     = 10;

   localparam logic [BEST_W-1:0] PREP_START = 16'hFFFF;
   localparam logic [BEST_W-1:0] SCAN_START = 16'h7FFF;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_PREP  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]      mode;
      logic [5:0]      slot;
      logic [IN_W-1:0] pos_x;
      logic [IN_W-1:0] pos_y;
      logic [IN_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] nearest_label;
      logic               radius_hit;
   } rsp_type;

   typedef struct packed {
      logic load_wr;
      logic load_query;
      logic load_center;
      logic init_prep;
      logic issue;
      logic hit_en;
      logic prep_mode;
      logic attr_wr;
      logic swap0;
      logic swap1;
   } nss_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic hit;
   } nss_stat_type;

endpackage

// ===== hdl/nss_ram.sv =====
`timescale 1ns / 1ps

module nss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/nss_datapath.sv =====
`timescale 1ns / 1ps

module nss_datapath import nss_pkg::*; #(
   parameter int MAX_SEEDS  = 64,
   parameter int COORD_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nss_cmd_type                  cmd,
   input  logic [$clog2(MAX_SEEDS)-1:0] rd_addr,
   input  logic [$clog2(MAX_SEEDS)-1:0] center_idx,
   input  req_type                      req_data,
   output nss_stat_type                 stat,
   output rsp_type                      rsp_data
);

   localparam int AW = $clog2(MAX_SEEDS);
   localparam int CB = COORD_BITS;
   localparam int CRD_W = 3 * CB;
   localparam int DW = CB + 2;

   function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   logic              coord_we;
   logic [AW-1:0]     coord_waddr;
   logic [CRD_W-1:0]  coord_wdata;
   logic [CRD_W-1:0]  coord_rd;
   logic              attr_we;
   logic [AW-1:0]     attr_waddr;
   logic [ATTR_W-1:0] attr_wdata;
   logic [ATTR_W-1:0] attr_rd;

   logic [CB-1:0]     ref_x_ff, ref_y_ff, ref_z_ff;
   logic [CB-1:0]     ref_x_in, ref_y_in, ref_z_in;

   logic              p1_valid_ff, p1_valid_in;
   logic [AW-1:0]     p1_idx_ff;
   logic              p2_valid_ff, p2_valid_in;
   logic [AW-1:0]     p2_idx_ff;
   logic [DW-1:0]     p2_dist_ff, dist_now;
   logic [CRD_W-1:0]  p2_coord_ff;
   logic [ATTR_W-1:0] p2_attr_ff;

   logic [BEST_W-1:0]  best_ff, best_in;
   logic [LABEL_W-1:0] pick_label_ff, pick_label_in;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      hit_idx_ff;
   logic [CRD_W-1:0]   hit_coord_ff;
   logic [ATTR_W-1:0]  hit_attr_ff;
   logic [CRD_W-1:0]   save0_coord_ff;
   logic [ATTR_W-1:0]  save0_attr_ff;

   logic hit_now;
   logic better;

   nss_ram #(.WIDTH(CRD_W), .DEPTH(MAX_SEEDS)) coord_ram (
      .clock   (clock),
      .wr_en   (coord_we),
      .wr_addr (coord_waddr),
      .wr_data (coord_wdata),
      .rd_addr (rd_addr),
      .rd_data (coord_rd)
   );

   nss_ram #(.WIDTH(ATTR_W), .DEPTH(MAX_SEEDS)) attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (attr_waddr),
      .wr_data (attr_wdata),
      .rd_addr (rd_addr),
      .rd_data (attr_rd)
   );

   // write port selection
   always_comb begin
      coord_we    = cmd.load_wr | cmd.swap0 | cmd.swap1;
      coord_waddr = hit_idx_ff;
      coord_wdata = save0_coord_ff;
      priority if (cmd.load_wr) begin
         coord_waddr = AW'(req_data.slot);
         coord_wdata = {CB'(req_data.pos_x), CB'(req_data.pos_y), CB'(req_data.pos_z)};
      end else if (cmd.swap0) begin
         coord_waddr = '0;
         coord_wdata = hit_coord_ff;
      end
      attr_we    = cmd.attr_wr | cmd.swap0 | cmd.swap1;
      attr_waddr = hit_idx_ff;
      attr_wdata = save0_attr_ff;
      priority if (cmd.attr_wr) begin
         attr_waddr = center_idx;
         attr_wdata = {best_ff[BEST_W-1:1], LABEL_W'(center_idx)};
      end else if (cmd.swap0) begin
         attr_waddr = '0;
         attr_wdata = hit_attr_ff;
      end
   end

   // distance of the entry just read
   assign dist_now = DW'(abs_diff(ref_x_ff, coord_rd[CRD_W-1:2*CB]))
                   + DW'(abs_diff(ref_y_ff, coord_rd[2*CB-1:CB]))
                   + DW'(abs_diff(ref_z_ff, coord_rd[CB-1:0]));

   assign hit_now = p2_valid_ff && cmd.hit_en
                 && (BEST_W'(p2_dist_ff) <= BEST_W'(p2_attr_ff[ATTR_W-1:LABEL_W]));
   assign better  = p2_valid_ff && (BEST_W'(p2_dist_ff) < best_ff)
                 && !(cmd.prep_mode && (p2_idx_ff == center_idx));

   always_comb begin
      ref_x_in = ref_x_ff;
      ref_y_in = ref_y_ff;
      ref_z_in = ref_z_ff;
      priority if (cmd.load_query) begin
         ref_x_in = CB'(req_data.pos_x);
         ref_y_in = CB'(req_data.pos_y);
         ref_z_in = CB'(req_data.pos_z);
      end else if (cmd.load_center) begin
         ref_x_in = coord_rd[CRD_W-1:2*CB];
         ref_y_in = coord_rd[2*CB-1:CB];
         ref_z_in = coord_rd[CB-1:0];
      end
   end

   always_comb begin
      best_in       = best_ff;
      pick_label_in = pick_label_ff;
      priority if (cmd.load_query) begin
         best_in = SCAN_START;
      end else if (cmd.init_prep) begin
         best_in = PREP_START;
      end else if (better && !hit_now) begin
         best_in       = BEST_W'(p2_dist_ff);
         pick_label_in = p2_attr_ff[LABEL_W-1:0];
      end
   end

   assign p1_valid_in = cmd.issue && !hit_now;
   assign p2_valid_in = p1_valid_ff && !hit_now;
   assign hit_in      = cmd.load_query ? 1'b0 : (hit_ff | hit_now);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_x_ff      <= ref_x_in;
      ref_y_ff      <= ref_y_in;
      ref_z_ff      <= ref_z_in;
      p1_idx_ff     <= rd_addr;
      p2_idx_ff     <= p1_idx_ff;
      p2_dist_ff    <= dist_now;
      p2_coord_ff   <= coord_rd;
      p2_attr_ff    <= attr_rd;
      best_ff       <= best_in;
      pick_label_ff <= pick_label_in;
      if (hit_now) begin
         hit_idx_ff   <= p2_idx_ff;
         hit_coord_ff <= p2_coord_ff;
         hit_attr_ff  <= p2_attr_ff;
      end
      if (p2_valid_ff && !cmd.prep_mode && (p2_idx_ff == '0)) begin
         save0_coord_ff <= p2_coord_ff;
         save0_attr_ff  <= p2_attr_ff;
      end
   end

   assign stat.pipe_busy = p1_valid_ff | p2_valid_ff;
   assign stat.hit       = hit_now;

   assign rsp_data.nearest_label = hit_ff ? hit_attr_ff[LABEL_W-1:0] : pick_label_ff;
   assign rsp_data.radius_hit    = hit_ff;

`ifndef NO_ASSERTIONS
   a_hit_flushes: assert property (@(posedge clock) disable iff (reset)
      hit_now |=> !p1_valid_ff && !p2_valid_ff)
      else $error("pipeline not flushed after radius hit");

   a_swap_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (cmd.swap0 || cmd.swap1) |-> hit_ff)
      else $error("swap without a recorded hit");
`endif

endmodule

// ===== hdl/nss_ctrl.sv =====
`timescale 1ns / 1ps

module nss_ctrl import nss_pkg::*; #(
   parameter int MAX_SEEDS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  req_type                      req_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [COUNT_W-1:0]           csr_data,
   input  nss_stat_type                 stat,
   output nss_cmd_type                  cmd,
   output logic [$clog2(MAX_SEEDS)-1:0] rd_addr,
   output logic [$clog2(MAX_SEEDS)-1:0] center_idx,
   output logic                         rsp_strobe
);

   localparam int AW = $clog2(MAX_SEEDS);
   localparam int CW = $clog2(MAX_SEEDS + 1);
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b00000000001,
      ST_P_CENT  = 11'b00000000010,
      ST_P_CWAIT = 11'b00000000100,
      ST_P_SCAN  = 11'b00000001000,
      ST_P_DRAIN = 11'b00000010000,
      ST_P_WRITE = 11'b00000100000,
      ST_Q_SCAN  = 11'b00001000000,
      ST_Q_DRAIN = 11'b00010000000,
      ST_Q_SWAP0 = 11'b00100000000,
      ST_Q_SWAP1 = 11'b01000000000,
      ST_Q_DONE  = 11'b10000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CW-1:0]      ctr_ff, ctr_in;
   logic [CW-1:0]      iss_ff, iss_in;
   logic [NW-1:0]      cnt_ext;
   logic [CW-1:0]      n_act;
   logic [CW-1:0]      q_len;
   logic               accept;
   logic               slot_ok;

   assign cnt_ext = NW'(count_ff);
   assign n_act   = (cnt_ext > NW'(MAX_SEEDS)) ? CW'(MAX_SEEDS) : CW'(cnt_ext);
   assign q_len   = (n_act == '0) ? CW'(1) : n_act;
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign slot_ok = (32'(req_data.slot) < 32'(MAX_SEEDS));

   assign csr_ready  = 1'b1;
   assign count_in   = (csr_valid && csr_ready) ? csr_data : count_ff;
   assign center_idx = ctr_ff[AW-1:0];
   assign rsp_strobe = (state_ff == ST_Q_DONE);

   always_comb begin
      state_in = state_ff;
      ctr_in   = ctr_ff;
      iss_in   = iss_ff;
      cmd      = '0;
      rd_addr  = iss_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  MODE_LOAD: begin
                     cmd.load_wr = slot_ok;
                  end
                  MODE_PREP: begin
                     ctr_in = '0;
                     if (n_act != '0) begin
                        state_in = ST_P_CENT;
                     end
                  end
                  MODE_QUERY: begin
                     cmd.load_query = 1'b1;
                     iss_in         = '0;
                     state_in       = ST_Q_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_P_CENT: begin
            cmd.prep_mode = 1'b1;
            cmd.init_prep = 1'b1;
            rd_addr       = ctr_ff[AW-1:0];
            state_in      = ST_P_CWAIT;
         end
         ST_P_CWAIT: begin
            cmd.prep_mode   = 1'b1;
            cmd.load_center = 1'b1;
            iss_in          = '0;
            state_in        = ST_P_SCAN;
         end
         ST_P_SCAN: begin
            cmd.prep_mode = 1'b1;
            cmd.issue     = 1'b1;
            iss_in        = iss_ff + CW'(1);
            if (iss_ff + CW'(1) == n_act) begin
               state_in = ST_P_DRAIN;
            end
         end
         ST_P_DRAIN: begin
            cmd.prep_mode = 1'b1;
            if (!stat.pipe_busy) begin
               state_in = ST_P_WRITE;
            end
         end
         ST_P_WRITE: begin
            cmd.prep_mode = 1'b1;
            cmd.attr_wr   = 1'b1;
            ctr_in        = ctr_ff + CW'(1);
            state_in      = (ctr_ff + CW'(1) == n_act) ? ST_IDLE : ST_P_CENT;
         end
         ST_Q_SCAN: begin
            cmd.issue  = 1'b1;
            cmd.hit_en = (n_act != '0);
            iss_in     = iss_ff + CW'(1);
            priority if (stat.hit) begin
               state_in = ST_Q_SWAP0;
            end else if (iss_ff + CW'(1) == q_len) begin
               state_in = ST_Q_DRAIN;
            end
         end
         ST_Q_DRAIN: begin
            cmd.hit_en = (n_act != '0);
            priority if (stat.hit) begin
               state_in = ST_Q_SWAP0;
            end else if (!stat.pipe_busy) begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_SWAP0: begin
            cmd.swap0 = 1'b1;
            state_in  = ST_Q_SWAP1;
         end
         ST_Q_SWAP1: begin
            cmd.swap1 = 1'b1;
            state_in  = ST_Q_DONE;
         end
         ST_Q_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= COUNT_W'(1);
         ctr_ff   <= '0;
         iss_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ctr_ff   <= ctr_in;
         iss_ff   <= iss_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_SWAP1) |-> $past(state_ff == ST_Q_SWAP0))
      else $error("second swap write without the first");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_SCAN || state_ff == ST_Q_SCAN) |-> (iss_ff < q_len))
      else $error("scan index beyond seeds in use");

   a_prep_center_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_WRITE) |-> (ctr_ff < n_act))
      else $error("prepare center beyond seeds in use");
`endif

endmodule

// ===== hdl/nearest_seed_radius_shortcut.sv =====
// nearest seed labeller, 3d manhattan distance, with per-seed radius shortcut
// command channel: an item transfers when start is high and busy is low;
//   req_data.mode picks load seed, prepare or query, mode 3 does nothing
// load: written at the transfer edge, no result
// prepare: with n seeds in use, no result;
//   one center at a time, each a full pass over the n seeds in use
// query: scans the n seeds in use (one entry with a seed count of zero), a
//   radius hit at seed k ends the scan and two swap writes move it to the front; one seed
//   per cycle leaves the coordinate memory read port, which sets the rate
// result: rsp_strobe high for exactly one cycle with rsp_data; the receiver
//   cannot hold it off, so no stall path exists
// csr channel: csr_data (seed count) transfers on csr_valid and csr_ready,
//   csr_ready is always high; write only while busy is low
// reset: synchronous, active high; seed count returns to 1, seed memories
//   keep their contents and are undefined until loaded and prepared
`timescale 1ns / 1ps

module nearest_seed_radius_shortcut import nss_pkg::*; #(
   parameter int MAX_SEEDS  = 64,
   parameter int COORD_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   localparam int AW = $clog2(MAX_SEEDS);

   nss_cmd_type   cmd;
   nss_stat_type  stat;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] center_idx;

   nss_ctrl #(.MAX_SEEDS(MAX_SEEDS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .stat       (stat),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .center_idx (center_idx),
      .rsp_strobe (rsp_strobe)
   );

   nss_datapath #(.MAX_SEEDS(MAX_SEEDS), .COORD_BITS(COORD_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .center_idx (center_idx),
      .req_data   (req_data),
      .stat       (stat),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== bench/nearest_seed_radius_shortcut_test.sv =====
`timescale 1ns / 1ps

module nearest_seed_radius_shortcut_test import nss_pkg::*;;

   localparam int SLOTS = 64;
   localparam int COORD_MAX = 1023;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [1:0] MODE_NONE = 2'd3;

   typedef struct packed {
      logic               count_write;
      logic [COUNT_W-1:0] count;
      req_type            item;
      logic               typed;
      rsp_type            result;
   } plan_row_type;

   localparam plan_row_type DIRECTED [22] = '{
      '{1'b0, 7'd0, '{MODE_LOAD, 6'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_PREP, 6'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
      // lone seed covers everything
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 10'd1023, 10'd1023, 10'd1023}, 1'b1, '{6'd0, 1'b1}},
      '{1'b1, 7'd2, '0, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_LOAD, 6'd1, 10'd1023, 10'd1023, 10'd1023}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_PREP, 6'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 10'd0, 10'd0, 10'd0}, 1'b1, '{6'd0, 1'b1}},
      // hit on slot 1 moves it to the front
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 10'd1023, 10'd1023, 10'd1023}, 1'b1, '{6'd1, 1'b1}},
      // distance equal to the radius
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 10'd511, 10'd512, 10'd512}, 1'b0, '0},
      '{1'b1, 7'd0, '0, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_PREP, 6'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
      '{1'b1, 7'd3, '0, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_LOAD, 6'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_LOAD, 6'd1, 10'd100, 10'd0, 10'd0}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_LOAD, 6'd2, 10'd100, 10'd0, 10'd0}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_PREP, 6'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
      // three-way tie on a miss
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 10'd50, 10'd300, 10'd0}, 1'b0, '0},
      // zero radius from duplicate seeds
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 10'd100, 10'd0, 10'd0}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_NONE, 6'd63, 10'd1023, 10'd1023, 10'd1023}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_LOAD, 6'd63, 10'd1023, 10'd1023, 10'd1023}, 1'b0, '0},
      '{1'b0, 7'd0, '{MODE_QUERY, 6'd0, 10'd1023, 10'd0, 10'd512}, 1'b0, '0}
   };

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   req_type            req_data = '0;
   logic               csr_valid = 1'b0;
   logic [COUNT_W-1:0] csr_data = '0;
   logic               busy;
   logic               rsp_strobe;
   logic               csr_ready;
   rsp_type            rsp_data;

   logic [IN_W-1:0]     seed_px [SLOTS];
   logic [IN_W-1:0]     seed_py [SLOTS];
   logic [IN_W-1:0]     seed_pz [SLOTS];
   logic [RADIUS_W-1:0] seed_rad [SLOTS];
   logic [LABEL_W-1:0]  seed_lab [SLOTS];
   bit                  coord_ok [SLOTS];
   bit                  attr_ok [SLOTS];
   logic [COUNT_W-1:0]  count_reg = 7'd1;
   rsp_type             labels_due [$];
   int                  errors_seen = 0;
   int                  cycle_count = 0;

   nearest_seed_radius_shortcut uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int seeds_in_use();
      return (count_reg > SLOTS) ? SLOTS : int'(count_reg);
   endfunction

   function automatic int unsigned axis_gap(logic [IN_W-1:0] a, logic [IN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int unsigned span(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                        logic [IN_W-1:0] z, int k);
      return axis_gap(x, seed_px[k]) + axis_gap(y, seed_py[k]) + axis_gap(z, seed_pz[k]);
   endfunction

   // slots 0..n-1 must hold loaded seeds, and radii and labels when asked
   function automatic bit table_ready(int n, bit need_attr);
      if (n == 0)
         return !need_attr || attr_ok[0];
      for (int i = 0; i < n; i++)
         if (!coord_ok[i] || (need_attr && !attr_ok[i]))
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit label_voxel(input req_type item, output rsp_type res);
      int          n;
      int          pick;
      int unsigned best;
      int unsigned d;
      n = seeds_in_use();
      res = '0;
      case (item.mode)
         MODE_LOAD: begin
            seed_px[item.slot] = item.pos_x;
            seed_py[item.slot] = item.pos_y;
            seed_pz[item.slot] = item.pos_z;
            coord_ok[item.slot] = 1'b1;
            return 1'b0;
         end
         MODE_PREP: begin
            for (int i = 0; i < n; i++) begin
               best = PREP_START;
               for (int j = 0; j < n; j++) begin
                  if (j != i) begin
                     d = span(seed_px[i], seed_py[i], seed_pz[i], j);
                     if (d < best)
                        best = d;
                  end
               end
               seed_rad[i] = RADIUS_W'(best / 2);
               seed_lab[i] = LABEL_W'(i);
               attr_ok[i] = 1'b1;
            end
            return 1'b0;
         end
         MODE_QUERY: begin
            best = SCAN_START;
            pick = 0;
            for (int i = 0; i < n; i++) begin
               d = span(item.pos_x, item.pos_y, item.pos_z, i);
               if (d <= seed_rad[i]) begin
                  // move to front
                  {seed_px[0], seed_px[i]} = {seed_px[i], seed_px[0]};
                  {seed_py[0], seed_py[i]} = {seed_py[i], seed_py[0]};
                  {seed_pz[0], seed_pz[i]} = {seed_pz[i], seed_pz[0]};
                  {seed_rad[0], seed_rad[i]} = {seed_rad[i], seed_rad[0]};
                  {seed_lab[0], seed_lab[i]} = {seed_lab[i], seed_lab[0]};
                  res.nearest_label = seed_lab[0];
                  res.radius_hit = 1'b1;
                  return 1'b1;
               end
               if (d < best) begin
                  best = d;
                  pick = i;
               end
            end
            res.nearest_label = seed_lab[pick];
            res.radius_hit = 1'b0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [IN_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return IN_W'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   function automatic logic [IN_W-1:0] near(logic [IN_W-1:0] c, int spread);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0)
         v = 0;
      if (v > COORD_MAX)
         v = COORD_MAX;
      return IN_W'(v);
   endfunction

   task automatic send_item(input req_type item, input bit typed, input rsp_type typed_rsp);
      rsp_type res;
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (label_voxel(item, res))
         labels_due.push_back(typed ? typed_rsp : res);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_labels();
      start <= 1'b0;
      while (labels_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_seed_count(input logic [COUNT_W-1:0] value);
      int n;
      drain_labels();
      // a prepare gives no result, so allow for one still running
      n = seeds_in_use();
      repeat (n * (n + 6) + 16) @(posedge clock);
      while (busy) @(posedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_reg = value;
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] count_value, input int items,
                            input bit gaps);
      int              n;
      int              k;
      int              pick;
      req_type         item;
      rsp_type         no_rsp;
      logic [IN_W-1:0] bx;
      logic [IN_W-1:0] by;
      logic [IN_W-1:0] bz;
      no_rsp = '0;
      write_seed_count(count_value);
      n = seeds_in_use();
      bx = rand_coord();
      by = rand_coord();
      bz = rand_coord();
      // fill the table, partly clustered so that radii get small or zero
      for (int s = 0; s < n; s++) begin
         item.mode = MODE_LOAD;
         item.slot = 6'(s);
         if ($urandom_range(0, 2) == 0) begin
            item.pos_x = near(bx, 6);
            item.pos_y = near(by, 6);
            item.pos_z = near(bz, 6);
         end else begin
            item.pos_x = rand_coord();
            item.pos_y = rand_coord();
            item.pos_z = rand_coord();
         end
         send_item(item, 1'b0, no_rsp);
         if (gaps && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 15));
      end
      item = '0;
      item.mode = MODE_PREP;
      send_item(item, 1'b0, no_rsp);
      repeat (items) begin
         item.slot = 6'($urandom_range(0, SLOTS - 1));
         item.pos_x = rand_coord();
         item.pos_y = rand_coord();
         item.pos_z = rand_coord();
         pick = $urandom_range(0, 99);
         if (pick < 70 && table_ready(n, 1'b1)) begin
            item.mode = MODE_QUERY;
            if (n > 0 && $urandom_range(0, 1) == 1) begin
               k = $urandom_range(0, n - 1);
               item.pos_x = near(seed_px[k], 24);
               item.pos_y = near(seed_py[k], 24);
               item.pos_z = near(seed_pz[k], 24);
            end
         end else if (pick < 90) begin
            item.mode = MODE_LOAD;
         end else if (pick < 93 && table_ready(n, 1'b0)) begin
            item.mode = MODE_PREP;
         end else begin
            item.mode = MODE_NONE;
         end
         if (pick >= 98) begin
            drain_labels();
         end else begin
            send_item(item, 1'b0, no_rsp);
            if (gaps && $urandom_range(0, 4) == 0)
               pause_sender($urandom_range(1, 15));
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (labels_due.size() == 0) begin
            errors_seen++;
            $error("unexpected result: nearest_label %0d radius_hit %0d",
                   rsp_data.nearest_label, rsp_data.radius_hit);
         end else begin
            want = labels_due.pop_front();
            if (rsp_data.nearest_label !== want.nearest_label) begin
               errors_seen++;
               $error("nearest_label: expected %0d, got %0d",
                      want.nearest_label, rsp_data.nearest_label);
            end
            if (rsp_data.radius_hit !== want.radius_hit) begin
               errors_seen++;
               $error("radius_hit: expected %0d, got %0d",
                      want.radius_hit, rsp_data.radius_hit);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      plan_row_type       row;
      int                 n;
      int                 items;
      logic [COUNT_W-1:0] cv;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[r]) begin
         row = DIRECTED[r];
         if (row.count_write)
            write_seed_count(row.count);
         else
            send_item(row.item, row.typed, row.result);
      end
      for (int p = 0; p < 14; p++) begin
         case (p)
            0: cv = 7'd127;
            1: cv = 7'd1;
            2: cv = 7'd0;
            3: cv = 7'd2;
            4: cv = 7'd64;
            default: cv = COUNT_W'($urandom_range(1, 12));
         endcase
         items = (cv == 0) ? 30 : ((cv >= 32) ? 40 : 100);
         run_phase(cv, items, p < 12 && $urandom_range(0, 3) != 0);
      end
      drain_labels();
      n = seeds_in_use();
      repeat (n * (n + 6) + 16) @(posedge clock);
      while (busy) @(posedge clock);
      if (errors_seen == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
